// ===== rtl/f32ta_pkg.sv =====
package f32ta_pkg;

	localparam int FracW = 23;
	localparam int ExpW = 8;
	localparam int SigW = FracW + 1;
	localparam int LzW = 5;
	localparam logic [ExpW-1:0] ExpMax = 8'd254;
	localparam logic [30:0] MaxFinite = 31'h7F7FFFFF;

	typedef struct packed {
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} add_in_t;

	typedef struct packed {
		logic [31:0] sum_word;
		logic        overflow_flag;
		logic        underflow_flag;
	} add_out_t;

	// aligned operands after stage 1
	typedef struct packed {
		logic            same_sign;
		logic            res_sign;
		logic            zero_sign;
		logic [ExpW-1:0] exp_l;
		logic [SigW-1:0] sig_l;
		logic [SigW-1:0] sig_s;
	} align_t;

	// raw sum after stage 2
	typedef struct packed {
		logic            same_sign;
		logic            res_sign;
		logic            zero_sign;
		logic [ExpW-1:0] exp_l;
		logic [SigW:0]   mag;
	} raw_t;

endpackage

// ===== rtl/f32ta_align.sv =====
module f32ta_align import f32ta_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  add_in_t in_data,
	output logic    out_valid,
	output align_t  out_data
);

	logic [ExpW-1:0] ea, eb, el, es, d;
	logic [30:0] ka, kb;
	logic [SigW-1:0] ma, mb, ml, ms;
	logic a_big;
	align_t nxt;

	always_comb begin
		ea = in_data.operand_a[30:23];
		eb = in_data.operand_b[30:23];
		ka = (ea != '0) ? in_data.operand_a[30:0] : '0;
		kb = (eb != '0) ? in_data.operand_b[30:0] : '0;
		ma = (ea != '0) ? {1'b1, in_data.operand_a[22:0]} : '0;
		mb = (eb != '0) ? {1'b1, in_data.operand_b[22:0]} : '0;
		a_big = (ka >= kb);
		el = a_big ? ea : eb;
		es = a_big ? eb : ea;
		ml = a_big ? ma : mb;
		ms = a_big ? mb : ma;
		d = el - es;
		nxt.same_sign = (in_data.operand_a[31] == in_data.operand_b[31]);
		nxt.res_sign = a_big ? in_data.operand_a[31] : in_data.operand_b[31];
		nxt.zero_sign = in_data.operand_a[31];
		nxt.exp_l = el;
		nxt.sig_l = ml;
		nxt.sig_s = (d >= 8'd24) ? '0 : (ms >> d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

// ===== rtl/f32ta_addsub.sv =====
module f32ta_addsub import f32ta_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  align_t in_data,
	output logic   out_valid,
	output raw_t   out_data
);

	raw_t nxt;

	always_comb begin
		nxt.same_sign = in_data.same_sign;
		nxt.res_sign = in_data.res_sign;
		nxt.zero_sign = in_data.zero_sign;
		nxt.exp_l = in_data.exp_l;
		if (in_data.same_sign) begin
			nxt.mag = {1'b0, in_data.sig_l} + {1'b0, in_data.sig_s};
		end else begin
			nxt.mag = {1'b0, in_data.sig_l} - {1'b0, in_data.sig_s};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

// ===== rtl/f32ta_norm.sv =====
module f32ta_norm import f32ta_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  raw_t     in_data,
	output logic     out_valid,
	output add_out_t out_data
);

	logic [LzW-1:0] lz;
	logic [SigW-1:0] m;
	logic [ExpW:0] e;
	add_out_t nxt;

	// leading zero count within the 24-bit significand
	always_comb begin
		lz = LzW'(SigW);
		for (int i = 0; i < SigW; i++) begin
			if (in_data.mag[i]) lz = LzW'(SigW - 1 - i);
		end
	end

	always_comb begin
		nxt = '0;
		m = '0;
		e = '0;
		if (in_data.same_sign) begin
			if (in_data.mag == '0) begin
				nxt.sum_word = {in_data.zero_sign, 31'd0};
			end else begin
				if (in_data.mag[SigW]) begin
					m = in_data.mag[SigW:1];
					e = {1'b0, in_data.exp_l} + 9'd1;
				end else begin
					m = in_data.mag[SigW-1:0];
					e = {1'b0, in_data.exp_l};
				end
				if (e > {1'b0, ExpMax}) begin
					nxt.sum_word = {in_data.res_sign, MaxFinite};
					nxt.overflow_flag = 1'b1;
				end else begin
					nxt.sum_word = {in_data.res_sign, e[ExpW-1:0], m[FracW-1:0]};
				end
			end
		end else if (in_data.mag != '0) begin
			m = in_data.mag[SigW-1:0] << lz;
			if ({1'b0, in_data.exp_l} < ({4'd0, lz} + 9'd1)) begin
				nxt.sum_word = {in_data.res_sign, 31'd0};
				nxt.underflow_flag = 1'b1;
			end else begin
				e = {1'b0, in_data.exp_l} - {4'd0, lz};
				if (e > {1'b0, ExpMax}) begin
					nxt.sum_word = {in_data.res_sign, MaxFinite};
					nxt.overflow_flag = 1'b1;
				end else begin
					nxt.sum_word = {in_data.res_sign, e[ExpW-1:0], m[FracW-1:0]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

// ===== rtl/float32_truncating_adder_core.sv =====
// single-precision adder without rounding: one operation may start every
// cycle and its result appears with done high after passing the registered
// align, add/subtract and normalize stages; busy is always low since the
// pipeline never stalls, and done must be taken when shown
module float32_truncating_adder_core import f32ta_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  add_in_t  operands,
	output logic     done,
	output add_out_t result
);

	logic v_s1, v_s2;
	align_t d_s1;
	raw_t d_s2;

	assign busy = 1'b0;

	f32ta_align u_align (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .in_data(operands),
		.out_valid(v_s1), .out_data(d_s1)
	);

	f32ta_addsub u_addsub (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .in_data(d_s1),
		.out_valid(v_s2), .out_data(d_s2)
	);

	f32ta_norm u_norm (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2), .in_data(d_s2),
		.out_valid(done), .out_data(result)
	);

endmodule

// ===== tb/float32_truncating_adder_core_test.sv =====
`timescale 1ns / 1ps

module float32_truncating_adder_core_test;
	import f32ta_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int DrainCycles = 8;
	localparam int RandomItems = 900;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	add_in_t  operands = '0;
	logic     done;
	add_out_t result;

	add_out_t sum_queue[$];
	int       mismatches = 0;
	int       idle_cycles = 0;
	bit       timed_out = 0;

	float32_truncating_adder_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operands(operands),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	// truncating float add, operand_a wins a magnitude tie
	function automatic add_out_t truncated_sum(input add_in_t op);
		add_out_t r;
		logic sa, sb, sl;
		logic [7:0] ea, eb, el, es;
		logic [30:0] ka, kb;
		logic [31:0] ml, ms, m, d, e, lz;
		r = '0;
		sa = op.operand_a[31];
		sb = op.operand_b[31];
		ea = op.operand_a[30:23];
		eb = op.operand_b[30:23];
		ka = (ea != 0) ? op.operand_a[30:0] : 31'd0;
		kb = (eb != 0) ? op.operand_b[30:0] : 31'd0;
		if (ka >= kb) begin
			sl = sa; el = ea; es = eb;
			ml = (ea != 0) ? {9'd1, op.operand_a[22:0]} : 32'd0;
			ms = (eb != 0) ? {9'd1, op.operand_b[22:0]} : 32'd0;
		end else begin
			sl = sb; el = eb; es = ea;
			ml = (eb != 0) ? {9'd1, op.operand_b[22:0]} : 32'd0;
			ms = (ea != 0) ? {9'd1, op.operand_a[22:0]} : 32'd0;
		end
		d = 32'(el - es);
		ms = (d >= 24) ? 32'd0 : (ms >> d);
		e = 32'(el);
		if (sa == sb) begin
			m = ml + ms;
			if (m == 0) begin
				r.sum_word = {sa, 31'd0};
			end else begin
				if (m[24]) begin
					m = m >> 1;
					e = e + 1;
				end
				if (e > ExpMax) begin
					r.sum_word = {sl, MaxFinite};
					r.overflow_flag = 1'b1;
				end else begin
					r.sum_word = {sl, e[7:0], m[22:0]};
				end
			end
		end else begin
			m = ml - ms;
			if (m != 0) begin
				lz = 0;
				while (!m[23] && lz < 24) begin
					m = m << 1;
					lz++;
				end
				if (e < lz + 1) begin
					r.sum_word = {sl, 31'd0};
					r.underflow_flag = 1'b1;
				end else begin
					e = e - lz;
					if (e > ExpMax) begin
						r.sum_word = {sl, MaxFinite};
						r.overflow_flag = 1'b1;
					end else begin
						r.sum_word = {sl, e[7:0], m[22:0]};
					end
				end
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 7))
			0: w[30:23] = 8'd0;
			1: w[30:23] = 8'hFF;
			2: w[30:23] = 8'($urandom_range(0, 3));
			3: w[30:23] = 8'($urandom_range(250, 254));
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_beat(input add_in_t op);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operands <= op;
		@(posedge clk);
		while (busy) @(posedge clk);
		sum_queue.push_back(truncated_sum(op));
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sum_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h ovf %b unf %b",
						result.sum_word, result.overflow_flag, result.underflow_flag);
			end else begin
				add_out_t want;
				want = sum_queue.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want %h/%b/%b got %h/%b/%b",
							want.sum_word, want.overflow_flag, want.underflow_flag,
							result.sum_word, result.overflow_flag,
							result.underflow_flag);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit && !timed_out) begin
			timed_out = 1;
			$display("FAILURE");
			$finish;
		end
	end

	// operand_a, operand_b, expected sum, ovf, unf, known
	typedef struct {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] s;
		logic        ovf;
		logic        unf;
		bit          known;
	} directed_row_t;

	directed_row_t directed[] = '{
		'{32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 1'b0, 1},
		'{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0, 1},
		'{32'h80000000, 32'h00000000, 32'h00000000, 1'b0, 1'b0, 1},
		'{32'h007FFFFF, 32'h807FFFFF, 32'h00000000, 1'b0, 1'b0, 1},
		'{32'h3F800000, 32'h00000000, 32'h3F800000, 1'b0, 1'b0, 1},
		'{32'h00000000, 32'hC0400000, 32'hC0400000, 1'b0, 1'b0, 1},
		'{32'h3F800000, 32'hBF800000, 32'h00000000, 1'b0, 1'b0, 1},
		'{32'hBF800000, 32'h3F800000, 32'h00000000, 1'b0, 1'b0, 1},
		'{32'h7F7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF, 1'b1, 1'b0, 1},
		'{32'hFF7FFFFF, 32'hFF000000, 32'hFF7FFFFF, 1'b1, 1'b0, 1},
		'{32'h7F800000, 32'h00000000, 32'h7F7FFFFF, 1'b1, 1'b0, 1},
		'{32'hFFFFFFFF, 32'h3F800000, 32'hFF7FFFFF, 1'b1, 1'b0, 1},
		'{32'h00800001, 32'h80800000, 32'h00000000, 1'b0, 1'b1, 1},
		'{32'h80FFFFFF, 32'h00800000, 32'h00000000, 1'b0, 1'b0, 0},
		'{32'h3F800000, 32'h33800000, 32'h3F800000, 1'b0, 1'b0, 1},
		'{32'h3F800000, 32'h34000000, 32'h00000000, 1'b0, 1'b0, 0},
		'{32'h3F800000, 32'hB3FFFFFF, 32'h00000000, 1'b0, 1'b0, 0},
		'{32'h3FFFFFFF, 32'h3FFFFFFF, 32'h00000000, 1'b0, 1'b0, 0},
		'{32'h40000000, 32'hBFFFFFFF, 32'h00000000, 1'b0, 1'b0, 0},
		'{32'h4B000001, 32'hCB000000, 32'h00000000, 1'b0, 1'b0, 0},
		'{32'hBF800000, 32'h40000000, 32'h00000000, 1'b0, 1'b0, 0},
		'{32'h12345678, 32'h9ABCDEF0, 32'h00000000, 1'b0, 1'b0, 0}
	};

	initial begin
		add_in_t op;
		add_out_t typed;
		int guard;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			op.operand_a = directed[i].a;
			op.operand_b = directed[i].b;
			if (directed[i].known) begin
				typed = '{directed[i].s, directed[i].ovf, directed[i].unf};
				if (typed !== truncated_sum(op))
					$display("directed row %0d disagrees with predictor", i);
			end
			send_beat(op);
		end
		for (int i = 0; i < RandomItems; i++) begin
			op.operand_a = random_word();
			// half the time pick a close neighbor to exercise cancellation
			if ($urandom_range(0, 1)) begin
				op.operand_b = op.operand_a ^ ($urandom_range(0, 1) << 31);
				op.operand_b[22:0] = op.operand_b[22:0] ^ 23'($urandom & 32'h3F);
				op.operand_b[30:23] = 8'(op.operand_b[30:23] + $urandom_range(0, 2) - 1);
			end else begin
				op.operand_b = random_word();
			end
			send_beat(op);
		end
		start <= 1'b0;
		guard = 0;
		while (sum_queue.size() != 0 && guard < WatchdogLimit) begin
			@(posedge clk);
			guard++;
		end
		repeat (DrainCycles) @(posedge clk);
		if (sum_queue.size() == 0 && mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
